// ===== design/sdrs_pkg.sv =====
package sdrs_pkg;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_END_OF_DISK = 3'd1,
    ST_UNALIGNED  = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_QUEUE_FULL = 3'd4
  } status_e;

  localparam logic [7:0] ATA_READ_DMA      = 8'hC8;
  localparam logic [7:0] ATA_READ_DMA_EXT  = 8'h25;
  localparam logic [7:0] ATA_WRITE_DMA     = 8'hCA;
  localparam logic [7:0] ATA_WRITE_DMA_EXT = 8'h35;

  localparam logic [0:0] FUNC_SUBMIT = 1'b0;
  localparam logic [0:0] FUNC_DONE   = 1'b1;

  localparam logic [0:0] REG_BLOCK_LOG = 1'b0;
  localparam logic [0:0] REG_LBA48     = 1'b1;

  localparam int BLOCK_LOG_W = 4;

  typedef struct packed {
    logic [7:0]  tag;
    logic [31:0] offset;
    logic [31:0] length;
    logic        is_read;
  } entry_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] accepted_length;
    logic        issue_valid;
    logic [7:0]  issue_tag;
    logic [7:0]  ata_command;
    logic [22:0] block_lba;
    logic [31:0] progress_bytes;
    logic        complete_valid;
    logic [7:0]  complete_tag;
  } result_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  req_tag;
    logic        is_read;
    logic [31:0] byte_offset;
    logic [31:0] req_length;
    logic [31:0] device_size;
    logic [22:0] partition_base;
    logic [31:0] buffer_addr;
  } request_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input word
    logic eval;       // compute checks / advance
    logic scan;       // queue search step
    logic commit;     // apply state update
    logic shift_step; // one queue move step
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic drop;         // completion while idle
    logic need_insert;  // submit to be queued
    logic need_pop;     // request done, queue nonempty
    logic scan_done;
    logic shift_done;
  } dp_sts_t;

endpackage

// ===== design/sdrs_if.sv =====
interface sdrs_req_if;
  import sdrs_pkg::*;
  logic     valid;
  logic     ready;
  request_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sdrs_res_if;
  import sdrs_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sdrs_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== design/sdrs_ctrl.sv =====
module sdrs_ctrl
  import sdrs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EVAL  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_SHIFT = 6'b001000,
    S_COMMIT = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (sts_i.drop) begin
          state_d = S_IDLE;
        end else if (sts_i.need_insert) begin
          state_d = S_SCAN;
        end else if (sts_i.need_pop) begin
          state_d = S_SHIFT;
        end else begin
          state_d = S_COMMIT;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (sts_i.shift_done) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/sdrs_dp.sv =====
module sdrs_dp
  import sdrs_pkg::*;
#(
  parameter int QueueDepth = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  request_t               req_i,
  input  logic                   cfg_we_i,
  input  logic [0:0]             cfg_index_i,
  input  logic [31:0]            cfg_wdata_i,
  input  dp_cmd_t                cmd_i,
  output dp_sts_t                sts_o,
  output result_t                res_o
);

  localparam int IdxW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  logic [BLOCK_LOG_W-1:0] block_log_q;
  logic                   lba48_q;

  request_t    req_q;
  entry_t      queue_q [QueueDepth];
  logic [CntW-1:0] count_q;
  logic        busy_q;
  entry_t      cur_q;
  logic [31:0] prog_q;
  result_t     res_q;
  result_t     res_d;
  entry_t      head_q;

  // per-item working registers
  logic [2:0]  stat_q;
  logic [31:0] len_q;
  logic [31:0] abs_q;
  logic        done_q;     // completion finishes current request
  logic        finish_q;   // completion finishes, queue empty -> go idle
  logic [CntW-1:0] pos_q;  // scan / shift cursor
  logic [CntW-1:0] ins_q;  // insert position
  logic        ins_mode_q;

  logic [31:0] bsize, bmask, room, clip_len, abs_off, nxt_off;
  logic [32:0] sum;
  logic [2:0]  chk_stat;
  logic        chk_ok;

  assign bsize = 32'd1 << block_log_q;
  assign bmask = bsize - 32'd1;
  assign room  = req_q.device_size - req_q.byte_offset;
  assign clip_len = (req_q.req_length < room) ? req_q.req_length : room;
  assign abs_off  = req_q.byte_offset + ({9'd0, req_q.partition_base} << block_log_q);
  assign nxt_off  = cur_q.offset + bsize;
  assign sum      = {1'b0, prog_q} + {1'b0, bsize};

  always_comb begin
    chk_stat = ST_OK;
    chk_ok   = 1'b0;
    if (req_q.byte_offset >= req_q.device_size) begin
      chk_stat = req_q.is_read ? ST_EMPTY : ST_END_OF_DISK;
    end else if (((req_q.byte_offset & bmask) != 32'd0) ||
                 ((req_q.buffer_addr & bmask) != 32'd0)) begin
      chk_stat = ST_UNALIGNED;
    end else if ((clip_len & bmask) != 32'd0) begin
      chk_stat = ST_UNALIGNED;
    end else if (clip_len == 32'd0) begin
      chk_stat = ST_EMPTY;
    end else if (busy_q && (count_q >= CntW'(QueueDepth))) begin
      chk_stat = ST_QUEUE_FULL;
    end else begin
      chk_ok = 1'b1;
    end
  end

  logic [IdxW-1:0] pos_idx, pos_idx_m1;
  assign pos_idx    = pos_q[IdxW-1:0];
  assign pos_idx_m1 = pos_idx - IdxW'(1);

  always_comb begin
    sts_o = '0;
    sts_o.drop        = (req_q.func == FUNC_DONE) && !busy_q;
    sts_o.need_insert = (req_q.func == FUNC_SUBMIT) && chk_ok && busy_q;
    sts_o.need_pop    = (req_q.func == FUNC_DONE) && busy_q &&
                        (sum >= {1'b0, cur_q.length}) && (count_q != '0);
    sts_o.scan_done   = (pos_q == count_q) || (queue_q[pos_idx].offset > abs_q);
    sts_o.shift_done  = ins_mode_q ? (pos_q <= ins_q)
                                   : (pos_q >= count_q);
  end

  function automatic logic [7:0] opcode(input logic rd, input logic ext);
    if (rd) return ext ? ATA_READ_DMA_EXT : ATA_READ_DMA;
    return ext ? ATA_WRITE_DMA_EXT : ATA_WRITE_DMA;
  endfunction

  // pop reads head before shift overwrites it: capture head at eval
  always_comb begin
    res_d = '0;
    if (req_q.func == FUNC_DONE) begin
      res_d.complete_valid = done_q;
      res_d.complete_tag   = done_q ? cur_q.tag : 8'd0;
      if (!finish_q) begin
        res_d.issue_valid = 1'b1;
        if (done_q) begin
          res_d.issue_tag      = head_q.tag;
          res_d.ata_command    = opcode(head_q.is_read, lba48_q);
          res_d.block_lba      = 23'(head_q.offset >> block_log_q);
          res_d.progress_bytes = '0;
        end else begin
          res_d.issue_tag      = cur_q.tag;
          res_d.ata_command    = opcode(cur_q.is_read, lba48_q);
          res_d.block_lba      = 23'(nxt_off >> block_log_q);
          res_d.progress_bytes = sum[31:0];
        end
      end
    end else begin
      res_d.status = stat_q;
      if (stat_q == ST_OK) begin
        res_d.accepted_length = len_q;
        if (!busy_q) begin
          res_d.issue_valid = 1'b1;
          res_d.issue_tag   = req_q.req_tag;
          res_d.ata_command = opcode(req_q.is_read, lba48_q);
          res_d.block_lba   = 23'(abs_q >> block_log_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_log_q <= 4'd9;
      lba48_q     <= 1'b0;
      count_q     <= '0;
      busy_q      <= 1'b0;
      cur_q       <= '0;
      prog_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_BLOCK_LOG: block_log_q <= cfg_wdata_i[BLOCK_LOG_W-1:0];
          REG_LBA48:     lba48_q     <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (cmd_i.commit) begin
        if (req_q.func == FUNC_DONE) begin
          if (done_q && !finish_q) begin
            cur_q   <= head_q;
            prog_q  <= '0;
            count_q <= count_q - CntW'(1);
          end else begin
            cur_q.offset <= nxt_off;
            prog_q       <= sum[31:0];
            if (finish_q) begin
              busy_q <= 1'b0;
            end
          end
        end else if (stat_q == ST_OK) begin
          if (!busy_q) begin
            busy_q <= 1'b1;
            cur_q  <= '{tag: req_q.req_tag, offset: abs_q, length: len_q,
                        is_read: req_q.is_read};
            prog_q <= '0;
          end else begin
            count_q <= count_q + CntW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.eval) begin
      stat_q   <= chk_stat;
      len_q    <= clip_len;
      abs_q    <= abs_off;
      done_q   <= sum >= {1'b0, cur_q.length};
      finish_q <= (sum >= {1'b0, cur_q.length}) && (count_q == '0);
      pos_q    <= (req_q.func == FUNC_DONE) ? CntW'(1) : '0;
      ins_mode_q <= req_q.func == FUNC_SUBMIT;
      head_q   <= queue_q[0];
    end
    if (cmd_i.scan && !sts_o.scan_done) begin
      pos_q <= pos_q + CntW'(1);
    end
    if (cmd_i.scan && sts_o.scan_done) begin
      ins_q <= pos_q;
      pos_q <= count_q;
    end
    if (cmd_i.shift_step) begin
      if (ins_mode_q) begin
        if (pos_q > ins_q) begin
          queue_q[pos_idx] <= queue_q[pos_idx_m1];
          pos_q <= pos_q - CntW'(1);
        end else begin
          queue_q[pos_idx] <= '{tag: req_q.req_tag, offset: abs_q, length: len_q,
                                is_read: req_q.is_read};
        end
      end else if (pos_q < count_q) begin
        queue_q[pos_idx_m1] <= queue_q[pos_idx];
        pos_q <= pos_q + CntW'(1);
      end
    end
    if (cmd_i.commit) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== design/sorted_disk_request_sequencer.sv =====
// Channel | Dir | Handshake   | Word
// req     | in  | valid/ready | request_t (func, tag, offsets, sizes)
// res     | out | valid/ready | result_t (status, issue, completion)
// cfg     | in  | valid/ready | register index and write data
// A word passes through the IDLE, EVAL, COMMIT and OUT states; a queued
// submit adds the sorted scan (SCAN) and the shift (SHIFT) of the queue,
// and a pop that starts the next request adds a SHIFT pass that moves
// each queued entry. A completion while idle goes from EVAL back to IDLE and gives no word.
// Reset is asynchronous and active low; the queue needs no clearing.
// A stalled result holds the block until it is taken.
module sorted_disk_request_sequencer
  import sdrs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  sdrs_req_if.sink   req,
  sdrs_res_if.source res,
  sdrs_cfg_if.sink   cfg
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg.ready = 1'b1;

  sdrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (res.valid),
    .out_ready_i (res.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  sdrs_dp #(.QueueDepth(QUEUE_DEPTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req.data),
    .cfg_we_i    (cfg.valid),
    .cfg_index_i (cfg.index),
    .cfg_wdata_i (cfg.wdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res.data)
  );

endmodule

// ===== test/sorted_disk_request_sequencer_test.sv =====
module sorted_disk_request_sequencer_test;
  import sdrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int LIMIT = 3000000;

  class sequencer_scoreboard;
    logic [3:0] blk_log;
    logic lba48;
    entry_t pending[$];
    logic active;
    entry_t cur;
    logic [31:0] cur_progress;
    result_t expected[$];
    int errors;

    function new();
      blk_log = 4'd9;
      lba48 = 1'b0;
      active = 1'b0;
      cur = '0;
      cur_progress = '0;
      errors = 0;
    endfunction

    function logic [7:0] opcode(logic rd);
      if (rd) return lba48 ? ATA_READ_DMA_EXT : ATA_READ_DMA;
      return lba48 ? ATA_WRITE_DMA_EXT : ATA_WRITE_DMA;
    endfunction

    function void fill_issue(ref result_t r);
      r.issue_valid = 1'b1;
      r.issue_tag = cur.tag;
      r.ata_command = opcode(cur.is_read);
      r.block_lba = 23'(cur.offset >> blk_log);
      r.progress_bytes = cur_progress;
    endfunction

    function void note_word(request_t w);
      result_t r;
      logic [31:0] bmask, room, len, absoff;
      logic [32:0] sum;
      entry_t e;
      int pos;
      r = '0;
      bmask = (32'd1 << blk_log) - 32'd1;
      if (w.func == FUNC_DONE) begin
        if (!active) return;
        cur.offset = cur.offset + (32'd1 << blk_log);
        sum = {1'b0, cur_progress} + (33'd1 << blk_log);
        cur_progress = sum[31:0];
        if (sum >= {1'b0, cur.length}) begin
          r.complete_valid = 1'b1;
          r.complete_tag = cur.tag;
          if (pending.size() == 0) begin
            active = 1'b0;
            expected.push_back(r);
            return;
          end
          cur = pending.pop_front();
          cur_progress = '0;
        end
        fill_issue(r);
        expected.push_back(r);
        return;
      end
      room = w.device_size - w.byte_offset;
      len = (w.req_length < room) ? w.req_length : room;
      if (w.byte_offset >= w.device_size)
        r.status = w.is_read ? ST_EMPTY : ST_END_OF_DISK;
      else if ((w.byte_offset & bmask) != 0 || (w.buffer_addr & bmask) != 0)
        r.status = ST_UNALIGNED;
      else if ((len & bmask) != 0) r.status = ST_UNALIGNED;
      else if (len == 0) r.status = ST_EMPTY;
      else begin
        absoff = w.byte_offset + ({9'd0, w.partition_base} << blk_log);
        e.tag = w.req_tag;
        e.offset = absoff;
        e.length = len;
        e.is_read = w.is_read;
        if (!active) begin
          active = 1'b1;
          cur = e;
          cur_progress = '0;
          r.accepted_length = len;
          fill_issue(r);
        end else if (pending.size() >= DEPTH) r.status = ST_QUEUE_FULL;
        else begin
          pos = 0;
          while (pos < pending.size() && pending[pos].offset <= absoff) pos++;
          pending.insert(pos, e);
          r.accepted_length = len;
        end
      end
      expected.push_back(r);
    endfunction

    task check_word(result_t got);
      result_t w;
      if (expected.size() == 0) begin
        report("unexpected word", 0, got);
        return;
      end
      w = expected.pop_front();
      if (got.status !== w.status) report("status", w.status, got.status);
      if (got.accepted_length !== w.accepted_length)
        report("accepted_length", w.accepted_length, got.accepted_length);
      if (got.issue_valid !== w.issue_valid)
        report("issue_valid", w.issue_valid, got.issue_valid);
      if (got.issue_tag !== w.issue_tag) report("issue_tag", w.issue_tag, got.issue_tag);
      if (got.ata_command !== w.ata_command)
        report("ata_command", w.ata_command, got.ata_command);
      if (got.block_lba !== w.block_lba) report("block_lba", w.block_lba, got.block_lba);
      if (got.progress_bytes !== w.progress_bytes)
        report("progress_bytes", w.progress_bytes, got.progress_bytes);
      if (got.complete_valid !== w.complete_valid)
        report("complete_valid", w.complete_valid, got.complete_valid);
      if (got.complete_tag !== w.complete_tag)
        report("complete_tag", w.complete_tag, got.complete_tag);
    endtask

    task report(string what, logic [191:0] exp_v, logic [191:0] got_v);
      errors++;
      $display("mismatch %s: expected %0h got %0h", what, exp_v, got_v);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  sdrs_req_if req();
  sdrs_res_if res();
  sdrs_cfg_if cfg();
  sequencer_scoreboard sb;
  logic quiet = 1'b0;
  int cycles = 0;

  sorted_disk_request_sequencer #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req(req.sink), .res(res.source), .cfg(cfg.sink)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    req.valid = 1'b0;
    req.data = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.wdata = '0;
    sb = new();
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("sorted_disk_request_sequencer_test failed");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && res.valid && res.ready) sb.check_word(res.data);

  // result side ready with random stall bursts
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        res.ready <= 1'b0;
        n = $urandom_range(1, 18);
        repeat (n) @(negedge clk_i);
      end
      res.ready <= 1'b1;
    end
  end

  // valid stays high after a word; the block is busy until a new word is set
  task send_word(request_t w);
    int n;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      req.valid <= 1'b0;
      n = $urandom_range(1, 18);
      repeat (n) @(negedge clk_i);
    end
    req.data <= w;
    req.valid <= 1'b1;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    sb.note_word(w);
    @(negedge clk_i);
  endtask

  task drain;
    req.valid <= 1'b0;
    while (sb.expected.size() != 0) @(negedge clk_i);
    repeat (2 * DEPTH + 20) @(negedge clk_i);
  endtask

  task write_reg(logic [0:0] idx, logic [31:0] v);
    drain();
    cfg.index <= idx;
    cfg.wdata <= v;
    cfg.valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    if (idx == REG_BLOCK_LOG) sb.blk_log = v[3:0];
    else sb.lba48 = v[0];
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  function request_t done_word();
    request_t w;
    w = '0;
    w.func = FUNC_DONE;
    w.req_tag = 8'($urandom);
    w.byte_offset = $urandom;
    return w;
  endfunction

  // aligned submit, mostly short so requests finish in a few blocks
  function request_t good_word(logic [3:0] bl);
    request_t w;
    w.func = FUNC_SUBMIT;
    w.req_tag = 8'($urandom);
    w.is_read = 1'($urandom);
    w.byte_offset = ($urandom_range(0, 63) << bl);
    w.device_size = w.byte_offset + ($urandom_range(1, 64) << bl);
    w.req_length = ($urandom_range(0, 5) << bl);
    if ($urandom_range(0, 15) == 0) w.req_length = $urandom;
    w.partition_base = ($urandom_range(0, 3) == 0) ? 23'($urandom) : 23'($urandom_range(0, 7));
    w.buffer_addr = $urandom & ~((32'd1 << bl) - 32'd1);
    if ($urandom_range(0, 15) == 0) w.buffer_addr = $urandom;
    return w;
  endfunction

  function request_t noise_word();
    request_t w;
    logic [191:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    w = bits[$bits(request_t)-1:0];
    w.func = FUNC_SUBMIT;
    return w;
  endfunction

  task random_phase(int count);
    int k;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0: send_word(noise_word());
        1, 2, 3, 4: send_word(done_word());
        default: send_word(good_word(sb.blk_log));
      endcase
    end
  endtask

  initial begin
    request_t w;
    int k;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    write_reg(REG_BLOCK_LOG, 32'd9);
    write_reg(REG_LBA48, 32'd0);
    // directed
    send_word(done_word());
    w = good_word(4'd9); w.byte_offset = 32'd4096; w.device_size = 32'd4096;
    w.is_read = 1'b1; send_word(w);
    w.is_read = 1'b0; send_word(w);
    w = good_word(4'd9); w.byte_offset = 32'd100; send_word(w);
    w = good_word(4'd9); w.buffer_addr = 32'd3; send_word(w);
    w = good_word(4'd9); w.req_length = 32'd700; send_word(w);
    w = good_word(4'd9); w.req_length = 32'd0; send_word(w);
    w = good_word(4'd9); w.byte_offset = 32'hFFFF_FE00; w.device_size = 32'hFFFF_FFFF;
    w.partition_base = 23'h7FFFFF; w.req_length = 32'hFFFF_FFFF; send_word(w);
    for (k = 0; k < DEPTH + 2; k++) begin
      w = good_word(4'd9); w.req_length = 32'd512;
      if (k < 3) w.byte_offset = 32'd512;
      send_word(w);
    end
    for (k = 0; k < DEPTH + 3; k++) send_word(done_word());
    // pause until everything has come back
    drain();
    random_phase(300);
    write_reg(REG_LBA48, 32'd1);
    write_reg(REG_BLOCK_LOG, 32'd15);
    random_phase(300);
    write_reg(REG_BLOCK_LOG, 32'd0);
    random_phase(250);
    write_reg(REG_LBA48, 32'd0);
    write_reg(REG_BLOCK_LOG, 32'd12);
    random_phase(300);
    // block size change in mid request
    w = good_word(4'd12); w.req_length = 32'd16384; w.device_size = 32'hFFFF_0000;
    send_word(w);
    write_reg(REG_BLOCK_LOG, 32'd9);
    random_phase(250);
    write_reg(REG_BLOCK_LOG, 32'd10);
    write_reg(REG_LBA48, 32'd1);
    random_phase(250);
    quiet = 1'b1;
    random_phase(250);
    drain();
    if (sb.errors == 0) $display("sorted_disk_request_sequencer_test passed");
    else $display("sorted_disk_request_sequencer_test failed");
    $finish;
  end
endmodule
